// ----- hw/rtl/spp_pkg.sv -----
package spp_pkg;

	localparam int unsigned MaxSolidsDefault = 8;
	localparam int unsigned ValueWidth = 32;
	localparam int unsigned SolidFieldWidth = 3;

	typedef struct packed {
		logic signed [31:0] interval_low;
		logic signed [31:0] interval_high;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
		logic               final_solid;
	} solid_in_t;

	typedef struct packed {
		logic [2:0] first_solid;
		logic [2:0] second_solid;
		logic       pair_valid;
		logic       end_of_pairs;
	} pair_out_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SWEEP_RD,
		ST_SWEEP_DEC,
		ST_SWEEP_WAIT,
		ST_TEST_RD,
		ST_TEST_CMP,
		ST_EMIT,
		ST_FINISH
	} spp_state_t;

endpackage

// ----- hw/rtl/sweep_and_prune_pair_finder_core.sv -----
// Sweep-and-prune broad phase. Each accepted transaction loads one solid
// (numbered by arrival); solids beyond MAX_SOLIDS are dropped. The
// transaction marked final_solid loads its solid (if room remains) and
// starts the run, during which no input is taken. With N solids loaded, the
// 2N sweep-axis bounds are insertion-sorted as keys in a register array,
// one compare per cycle. The sweep then reads the bounds in order: an end
// bound takes its solid out of the active set; a start bound fetches the
// new solid's corners, tests them against each active solid in turn, emits
// each pair found and then makes the new solid active. A box test reads the
// active solid's six corners as one word from the box memory and compares
// them against the new solid's corners held in registers. Each pair is held
// back by one so that the last one leaves with end_of_pairs set; a run with
// no pair gives one empty marker with end_of_pairs set. Results leave
// through an output register, and a stalled receiver holds the run in
// place. Stores are not cleared; only entries of the current set are read.
module sweep_and_prune_pair_finder_core #(
	parameter int unsigned MAX_SOLIDS = spp_pkg::MaxSolidsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  spp_pkg::solid_in_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output spp_pkg::pair_out_t out_data
);
	localparam int unsigned SW = $clog2(MAX_SOLIDS);
	localparam int unsigned CW = $clog2(MAX_SOLIDS + 1);
	localparam int unsigned NB = 2 * MAX_SOLIDS;
	localparam int unsigned BW = $clog2(NB);
	localparam int unsigned BCW = $clog2(NB + 1);
	localparam int unsigned VW = spp_pkg::ValueWidth;
	localparam int unsigned XBW = 6 * VW;
	localparam int unsigned KW = VW + SW + 1;

	// key: biased value, solid, end flag
	typedef logic [KW-1:0] key_t;

	spp_pkg::spp_state_t state_q, state_d;

	logic [CW-1:0]  loaded_q;
	logic [BCW-1:0] total_q;
	logic [BCW-1:0] i_q;
	logic [BW-1:0]  j_q;
	key_t           k_q;
	key_t           keys_q [NB];
	logic [MAX_SOLIDS-1:0] active_q;
	logic [SW-1:0]  s_q;
	logic [CW-1:0]  a_q;
	logic           found_q;
	logic [XBW-1:0] cur_q;
	logic [XBW-1:0] box_mem [MAX_SOLIDS];
	logic [XBW-1:0] box_rd_q;
	logic           ovalid_q;
	spp_pkg::pair_out_t odata_q, pend_q, out_next, new_pair;

	logic accept_in, store_en, out_free, load_out, boxes_touch;
	logic sort_place, scan_done, a_active;
	logic [SW-1:0] rd_addr;
	logic [SW-1:0] st_idx;
	key_t new_lo, new_hi;
	logic [VW-1:0] lo_b, hi_b;

	assign accept_in = in_valid && in_ready;
	assign store_en  = accept_in && (loaded_q < CW'(MAX_SOLIDS));
	assign st_idx    = SW'(loaded_q);
	assign lo_b = in_data.interval_low ^ 32'h8000_0000;
	assign hi_b = in_data.interval_high ^ 32'h8000_0000;
	assign new_lo = {lo_b, st_idx, 1'b0};
	assign new_hi = {hi_b, st_idx, 1'b1};
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;
	assign out_free  = !ovalid_q || out_ready;
	assign sort_place = (j_q == '0) || (keys_q[j_q - BW'(1)] <= k_q);
	assign scan_done = a_q >= loaded_q;
	assign a_active  = active_q[SW'(a_q)];

	// box memory: one word of six corners per solid, registered read
	always_ff @(posedge clk) begin
		if (store_en)
			box_mem[st_idx] <= {in_data.box_max_z, in_data.box_max_y, in_data.box_max_x,
				in_data.box_min_z, in_data.box_min_y, in_data.box_min_x};
		box_rd_q <= box_mem[rd_addr];
	end

	// inclusive overlap of the active solid's box with the new solid's box
	always_comb begin
		boxes_touch = 1'b1;
		for (int c = 0; c < 3; c++) begin
			if ($signed(box_rd_q[VW*c +: VW]) > $signed(cur_q[VW*(c+3) +: VW]) ||
				$signed(cur_q[VW*c +: VW]) > $signed(box_rd_q[VW*(c+3) +: VW]))
				boxes_touch = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spp_pkg::ST_LOAD:
				if (accept_in && in_data.final_solid)
					state_d = spp_pkg::ST_SORT_RD;
			spp_pkg::ST_SORT_RD:
				state_d = (i_q >= total_q) ? spp_pkg::ST_SWEEP_RD : spp_pkg::ST_SORT_CMP;
			spp_pkg::ST_SORT_CMP:
				if (sort_place)
					state_d = spp_pkg::ST_SORT_RD;
			spp_pkg::ST_SWEEP_RD:
				state_d = (i_q >= total_q) ? spp_pkg::ST_FINISH : spp_pkg::ST_SWEEP_DEC;
			spp_pkg::ST_SWEEP_DEC:
				if (keys_q[BW'(i_q)][0])
					state_d = spp_pkg::ST_SWEEP_RD;
				else
					state_d = spp_pkg::ST_SWEEP_WAIT;
			spp_pkg::ST_SWEEP_WAIT:
				state_d = spp_pkg::ST_TEST_RD;
			spp_pkg::ST_TEST_RD:
				if (scan_done)
					state_d = spp_pkg::ST_SWEEP_RD;
				else if (a_active)
					state_d = spp_pkg::ST_TEST_CMP;
			spp_pkg::ST_TEST_CMP:
				state_d = boxes_touch ? spp_pkg::ST_EMIT : spp_pkg::ST_TEST_RD;
			spp_pkg::ST_EMIT:
				if (!found_q || out_free)
					state_d = spp_pkg::ST_TEST_RD;
			spp_pkg::ST_FINISH:
				if (out_free)
					state_d = spp_pkg::ST_LOAD;
			default:
				state_d = spp_pkg::ST_LOAD;
		endcase
	end

	// outputs: input handshake, memory address and result loading
	always_comb begin
		in_ready = (state_q == spp_pkg::ST_LOAD);
		rd_addr  = (state_q == spp_pkg::ST_SWEEP_DEC) ? s_q : SW'(a_q);
		new_pair = '{first_solid: 3'(a_q), second_solid: 3'(s_q),
			pair_valid: 1'b1, end_of_pairs: 1'b0};
		load_out = 1'b0;
		out_next = pend_q;
		case (state_q)
			spp_pkg::ST_EMIT:
				load_out = found_q && out_free;
			spp_pkg::ST_FINISH: begin
				load_out = out_free;
				if (found_q)
					out_next.end_of_pairs = 1'b1;
				else
					out_next = '{first_solid: 3'd0, second_solid: 3'd0,
						pair_valid: 1'b0, end_of_pairs: 1'b1};
			end
			default: ;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= spp_pkg::ST_LOAD;
			loaded_q <= '0;
			active_q <= '0;
			ovalid_q <= 1'b0;
			found_q  <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			a_q      <= '0;
			s_q      <= '0;
			k_q      <= '0;
			total_q  <= '0;
			odata_q  <= '0;
			pend_q   <= '0;
			for (int b = 0; b < NB; b++)
				keys_q[b] <= '0;
		end else begin
			state_q <= state_d;
			// load the output register, or drop the transaction once taken
			if (load_out) begin
				ovalid_q <= 1'b1;
				odata_q  <= out_next;
			end else if (out_ready)
				ovalid_q <= 1'b0;
			case (state_q)
				spp_pkg::ST_LOAD: begin
					if (store_en) begin
						keys_q[BW'(2 * st_idx)]     <= new_lo;
						keys_q[BW'(2 * st_idx + 1)] <= new_hi;
						loaded_q <= loaded_q + CW'(1);
					end
					if (accept_in && in_data.final_solid) begin
						total_q <= store_en ? BCW'(2 * (loaded_q + CW'(1)))
							: BCW'(2 * loaded_q);
						i_q     <= BCW'(1);
						active_q <= '0;
						found_q <= 1'b0;
					end
				end
				spp_pkg::ST_SORT_RD: begin
					if (i_q < total_q) begin
						k_q <= keys_q[BW'(i_q)];
						j_q <= BW'(i_q);
					end else
						i_q <= '0;
				end
				spp_pkg::ST_SORT_CMP: begin
					if (sort_place) begin
						keys_q[j_q] <= k_q;
						i_q <= i_q + BCW'(1);
					end else begin
						keys_q[j_q] <= keys_q[j_q - BW'(1)];
						j_q <= j_q - BW'(1);
					end
				end
				spp_pkg::ST_SWEEP_RD: begin
					if (i_q >= total_q) begin
						loaded_q <= '0;
						active_q <= '0;
					end else
						s_q <= keys_q[BW'(i_q)][SW:1];
				end
				spp_pkg::ST_SWEEP_DEC: begin
					if (keys_q[BW'(i_q)][0]) begin
						active_q[s_q] <= 1'b0;
						i_q <= i_q + BCW'(1);
					end
				end
				spp_pkg::ST_SWEEP_WAIT: begin
					a_q <= '0;
				end
				spp_pkg::ST_TEST_RD: begin
					if (scan_done) begin
						active_q[s_q] <= 1'b1;
						i_q <= i_q + BCW'(1);
					end else if (!a_active)
						a_q <= a_q + CW'(1);
				end
				spp_pkg::ST_TEST_CMP: begin
					if (!boxes_touch)
						a_q <= a_q + CW'(1);
				end
				spp_pkg::ST_EMIT: begin
					// hold the new pair back until the next one or the end of the run
					if (!found_q || out_free) begin
						pend_q  <= new_pair;
						found_q <= 1'b1;
						a_q     <= a_q + CW'(1);
					end
				end
				spp_pkg::ST_FINISH: begin
					if (out_free)
						found_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// new solid's corners for the box test
	always_ff @(posedge clk) begin
		if (state_q == spp_pkg::ST_SWEEP_WAIT)
			cur_q <= box_rd_q;
	end

endmodule

// ----- hw/rtl/spp_checker.sv -----
module spp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input spp_pkg::pair_out_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pair_valid |-> out_data.first_solid != out_data.second_solid)
		else $error("pair of a solid with itself");
	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.pair_valid |-> out_data.end_of_pairs)
		else $error("empty marker without end flag");
endmodule

bind sweep_and_prune_pair_finder_core spp_checker u_spp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
